// File: sv/gifa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gifa_pkg;

  localparam int unsigned OpW    = 2;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned LenW   = 9;
  localparam int unsigned GapW   = 7;
  localparam int unsigned TimerW = 8;

  // Bit 7 of the gap timer marks it armed; bits 6..0 count down.
  localparam logic [TimerW-1:0] ArmBit        = 8'h80;
  localparam logic [GapW-1:0]   GapTicksReset = 7'd4;

  typedef enum logic [OpW-1:0] {
    OpByte    = 2'd0,
    OpTick    = 2'd1,
    OpRead    = 2'd2,
    OpRelease = 2'd3
  } gifa_op_e;

  typedef struct packed {
    logic we;
    logic re;
  } gifa_mem_ctl_t;

  typedef struct packed {
    logic            frame_ready;
    logic [LenW-1:0] frame_length;
    logic            frame_closed;
    logic            rd_hit;
  } gifa_meta_t;

  typedef struct packed {
    logic s1_valid;
    logic out_valid;
  } gifa_stat_t;

endpackage

`default_nettype wire

// File: sv/gifa_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface gifa_in_if import gifa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OpW-1:0]    opcode;
  logic [ByteW-1:0]  rx_byte;
  logic [ByteW-1:0]  byte_index;

  modport source (output valid, output opcode, output rx_byte, output byte_index,
                  input ready);
  modport sink   (input valid, input opcode, input rx_byte, input byte_index,
                  output ready);
endinterface

interface gifa_out_if import gifa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              frame_ready;
  logic [LenW-1:0]   frame_length;
  logic [ByteW-1:0]  read_data;
  logic              frame_closed;

  modport source (output valid, output frame_ready, output frame_length,
                  output read_data, output frame_closed, input ready);
  modport sink   (input valid, input frame_ready, input frame_length,
                  input read_data, input frame_closed, output ready);
endinterface

`default_nettype wire

// File: sv/gifa_mem.sv
`timescale 1ns / 1ps
`default_nettype none

// Frame byte store: one port, synchronous read with registered data.
module gifa_mem import gifa_pkg::*; #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  wire logic              clk_i,
  input  wire gifa_mem_ctl_t     ctl_i,
  input  wire logic [AW-1:0]     addr_i,
  input  wire logic [ByteW-1:0]  wdata_i,
  output logic [ByteW-1:0]       rdata_o
);

  logic [ByteW-1:0] mem_q [DEPTH];
  logic [ByteW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.we) begin
      mem_q[addr_i] <= wdata_i;
    end
  end

  // The read data only moves on a read, so it holds while the stage stalls.
  always_ff @(posedge clk_i) begin
    if (ctl_i.re) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: sv/gifa_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

// Framing control: slot pointers, byte count, gap timer, recorded lengths.
module gifa_ctrl import gifa_pkg::*; #(
  parameter int unsigned FRAME_BYTES = 256,
  parameter int unsigned SLOT_COUNT  = 4,
  parameter int unsigned AW          = 10
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              accept_i,
  input  wire logic [OpW-1:0]    opcode_i,
  input  wire logic [ByteW-1:0]  rx_byte_i,
  input  wire logic [ByteW-1:0]  byte_index_i,
  input  wire logic              cfg_we_i,
  input  wire logic [GapW-1:0]   cfg_wdata_i,
  output gifa_mem_ctl_t          mem_ctl_o,
  output logic [AW-1:0]          mem_addr_o,
  output logic [ByteW-1:0]       mem_wdata_o,
  output gifa_meta_t             meta_o
);

  localparam int unsigned SW = $clog2(SLOT_COUNT);
  localparam int unsigned OW = $clog2(FRAME_BYTES);

  logic [SW-1:0]     ws_q, ws_d, rs_q, rs_d;
  logic [LenW-1:0]   cnt_q, cnt_d, cnt_eff;
  logic [TimerW-1:0] timer_q, timer_d;
  logic [GapW-1:0]   gap_q;
  logic [LenW-1:0]   len_q [SLOT_COUNT];
  logic              close;
  logic              hit;
  logic [SW-1:0]     slot_sel;
  logic [OW-1:0]     offset;
  logic [LenW-1:0]   len_fwd;
  gifa_op_e          op;

  function automatic logic [SW-1:0] next_slot(input logic [SW-1:0] s);
    next_slot = (s == SW'(SLOT_COUNT - 1)) ? '0 : s + 1'b1;
  endfunction

  assign op      = gifa_op_e'(opcode_i);
  assign cnt_eff = (cnt_q >= LenW'(FRAME_BYTES)) ? '0 : cnt_q;

  always_comb begin
    ws_d      = ws_q;
    rs_d      = rs_q;
    cnt_d     = cnt_q;
    timer_d   = timer_q;
    close     = 1'b0;
    hit       = 1'b0;
    mem_ctl_o = '0;
    slot_sel  = ws_q;
    offset    = cnt_eff[OW-1:0];
    if (accept_i) begin
      case (op)
        OpByte: begin
          mem_ctl_o.we = 1'b1;
          cnt_d        = cnt_eff + 1'b1;
          timer_d      = ArmBit | {1'b0, gap_q};
        end
        OpTick: begin
          if (timer_q[TimerW-1]) begin
            if (timer_q == ArmBit) begin
              timer_d = '0;
              close   = 1'b1;
              ws_d    = next_slot(ws_q);
              cnt_d   = '0;
            end else begin
              timer_d = timer_q - 1'b1;
            end
          end
        end
        OpRead: begin
          mem_ctl_o.re = 1'b1;
          slot_sel     = rs_q;
          offset       = byte_index_i[OW-1:0];
          hit          = (ws_q != rs_q) && ({1'b0, byte_index_i} < len_q[rs_q]);
        end
        OpRelease: begin
          if (ws_q != rs_q) begin
            rs_d = next_slot(rs_q);
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign mem_addr_o  = AW'(slot_sel) * AW'(FRAME_BYTES) + AW'(offset);
  assign mem_wdata_o = rx_byte_i;

  // The length written by a close is forwarded when it lands in the read slot.
  assign len_fwd = (close && (rs_d == ws_q)) ? cnt_q : len_q[rs_d];

  always_comb begin
    meta_o.frame_ready  = (ws_d != rs_d);
    meta_o.frame_length = (ws_d != rs_d) ? len_fwd : '0;
    meta_o.frame_closed = close;
    meta_o.rd_hit       = hit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ws_q    <= '0;
      rs_q    <= '0;
      cnt_q   <= '0;
      timer_q <= '0;
      gap_q   <= GapTicksReset;
    end else begin
      ws_q    <= ws_d;
      rs_q    <= rs_d;
      cnt_q   <= cnt_d;
      timer_q <= timer_d;
      if (cfg_we_i) begin
        gap_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (close) begin
      len_q[ws_q] <= cnt_q;
    end
  end

endmodule

`default_nettype wire

// File: sv/gifa_out.sv
`timescale 1ns / 1ps
`default_nettype none

// Memory read stage followed by the output register.
module gifa_out import gifa_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              accept_i,
  input  wire gifa_meta_t        meta_i,
  input  wire logic [ByteW-1:0]  rdata_i,
  output logic                   in_ready_o,
  output gifa_stat_t             stat_o,
  gifa_out_if.source             out_o
);

  logic            s1_valid_q, out_valid_q;
  gifa_meta_t      s1_meta_q;
  logic            adv;
  logic            out_ready_pl;
  logic [LenW-1:0] len_q;
  logic [ByteW-1:0] data_q;
  logic            fr_q, fc_q;

  assign out_ready_pl = !out_valid_q || out_o.ready;
  assign adv          = s1_valid_q && out_ready_pl;
  assign in_ready_o   = !s1_valid_q || out_ready_pl;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept_i) begin
        s1_valid_q <= 1'b1;
      end else if (adv) begin
        s1_valid_q <= 1'b0;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      s1_meta_q <= meta_i;
    end
    if (adv) begin
      fr_q   <= s1_meta_q.frame_ready;
      len_q  <= s1_meta_q.frame_length;
      fc_q   <= s1_meta_q.frame_closed;
      data_q <= s1_meta_q.rd_hit ? rdata_i : '0;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.frame_ready  = fr_q;
  assign out_o.frame_length = len_q;
  assign out_o.read_data    = data_q;
  assign out_o.frame_closed = fc_q;

  assign stat_o.s1_valid  = s1_valid_q;
  assign stat_o.out_valid = out_valid_q;

endmodule

`default_nettype wire

// File: sv/idle_gap_frame_assembler_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Payload                                          Moves when
// in_i      in   opcode, rx_byte, byte_index                      valid && ready
// out_o     out  frame_ready, frame_length, read_data, frame_closed  valid && ready
// cfg       in   cfg_wdata_i (gap_ticks)                          cfg_we_i
//
// One input beat is accepted per cycle while the output keeps up; its result passes
// through the synchronous byte read and then the output register.
// Reset clears pointers, count and timer and loads the gap register with 4; the byte memory and the
// recorded lengths stay undefined until written, so there is no clearing pass.
// Input ready falls when the read stage and the output register are both full
// and the output beat is not taken at that edge.

module idle_gap_frame_assembler_unit import gifa_pkg::*; #(
  parameter int unsigned FRAME_BYTES = 256,
  parameter int unsigned SLOT_COUNT  = 4
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic [GapW-1:0] cfg_wdata_i,
  gifa_in_if.sink              in_i,
  gifa_out_if.source           out_o
);

  localparam int unsigned DEPTH = SLOT_COUNT * FRAME_BYTES;
  localparam int unsigned AW    = $clog2(DEPTH);

  logic             accept;
  logic             in_ready;
  gifa_mem_ctl_t    mem_ctl;
  logic [AW-1:0]    mem_addr;
  logic [ByteW-1:0] mem_wdata;
  logic [ByteW-1:0] mem_rdata;
  gifa_meta_t       meta;
  gifa_stat_t       stat;

  assign in_i.ready = in_ready;
  assign accept     = in_i.valid && in_ready;

  // All control state but the gap register updates at the accepting edge, so the next
  // beat sees it directly; the memory only carries bytes, and a read in the cycle after a
  // write to the same entry already sees the written value.
  gifa_ctrl #(
    .FRAME_BYTES (FRAME_BYTES),
    .SLOT_COUNT  (SLOT_COUNT),
    .AW          (AW)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .opcode_i     (in_i.opcode),
    .rx_byte_i    (in_i.rx_byte),
    .byte_index_i (in_i.byte_index),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .mem_ctl_o    (mem_ctl),
    .mem_addr_o   (mem_addr),
    .mem_wdata_o  (mem_wdata),
    .meta_o       (meta)
  );

  gifa_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .ctl_i   (mem_ctl),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  gifa_out u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .meta_i     (meta),
    .rdata_i    (mem_rdata),
    .in_ready_o (in_ready),
    .stat_o     (stat),
    .out_o      (out_o)
  );

  // A nonzero read byte can only come from a waiting frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.read_data != '0)) |-> out_o.frame_ready)
    else $error("read data without a waiting frame");

  // Recorded lengths never exceed the slot size.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.frame_length <= LenW'(FRAME_BYTES)))
    else $error("frame length beyond slot size");

  // An accepted beat always occupies the read stage on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> stat.s1_valid)
    else $error("accepted beat lost before the read stage");

  // A full read stage with no room downstream must stall the input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stat.s1_valid && stat.out_valid && !out_o.ready) |-> !in_i.ready)
    else $error("input taken while the pipeline is full");

endmodule

`default_nettype wire
